// ===== rtl/ubf_pkg.sv =====
// Shared types and constants for the UART byte FIFO buffering block.
// No dependencies; used by every module of the block.
package ubf_pkg;

	// Field widths fixed by the interface
	localparam int DATA_W    = 8;
	localparam int MODE_W    = 2;
	localparam int COUNT_W   = 6;

	// Default ring depth (one slot always stays empty)
	localparam int DEPTH_DEF = 64;

	// Event codes carried on the mode port
	typedef enum logic [MODE_W-1:0] {
		MODE_RX_BYTE  = 2'd0,
		MODE_TX_READY = 2'd1,
		MODE_SW_READ  = 2'd2,
		MODE_SW_WRITE = 2'd3
	} mode_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_REPLY
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic latch;   // capture the incoming transaction
		logic exec;    // perform the push or pop
	} cmd_t;

endpackage

// ===== rtl/ubf_ctrl.sv =====
// Controller state machine of the UART byte FIFO buffering block.
// Depends on ubf_pkg for the state and command types.
module ubf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	output ubf_pkg::cmd_t cmd
);
	import ubf_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// Hold the current state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Advance on start; a new transaction may enter while a result is shown
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  state_nxt = start ? ST_EXEC : ST_IDLE;
			ST_EXEC:  state_nxt = ST_REPLY;
			ST_REPLY: state_nxt = start ? ST_EXEC : ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// Drive handshake and datapath commands
	always_comb begin
		busy      = (state_q == ST_EXEC);
		done      = (state_q == ST_REPLY);
		cmd.latch = start && (state_q != ST_EXEC);
		cmd.exec  = (state_q == ST_EXEC);
	end

endmodule

// ===== rtl/ubf_dpath.sv =====
// Datapath of the UART byte FIFO buffering block: two ring memories,
// their pointers, the transmit enable and the result registers. Depends on ubf_pkg.
module ubf_dpath #(
	parameter int DEPTH = ubf_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ubf_pkg::cmd_t               cmd,
	input  logic [ubf_pkg::MODE_W-1:0]  mode,
	input  logic [ubf_pkg::DATA_W-1:0]  data_in,
	output logic [ubf_pkg::DATA_W-1:0]  data_out,
	output logic                        ok,
	output logic                        tx_irq_enable,
	output logic [ubf_pkg::COUNT_W-1:0] rx_count,
	output logic [ubf_pkg::COUNT_W-1:0] tx_count
);
	import ubf_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_X = (PTR_W + 1 > COUNT_W) ? PTR_W + 1 : COUNT_W;
	localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);
	localparam logic [PTR_W:0]   DEPTH_X = (PTR_W + 1)'(DEPTH);

	logic [DATA_W-1:0] rx_mem [DEPTH];
	logic [DATA_W-1:0] tx_mem [DEPTH];

	logic [MODE_W-1:0] mode_q;
	logic [DATA_W-1:0] din_q;
	logic [DATA_W-1:0] rd_q;
	logic              ok_q;
	logic              tx_en_q;
	logic [PTR_W-1:0]  rx_w_q, rx_r_q, tx_w_q, tx_r_q;

	logic [PTR_W-1:0]  rx_w_nx, rx_r_nx, tx_w_nx, tx_r_nx;
	logic              rx_full, rx_empty, tx_full, tx_empty;
	logic              rx_push, rx_pop, tx_push, tx_pop;
	mode_t             op;

	function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
		return (p == LAST) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [COUNT_W-1:0] fill(input logic [PTR_W-1:0] w,
	                                             input logic [PTR_W-1:0] r);
		logic [PTR_W:0] diff;
		logic [CNT_X-1:0] ext;
		diff = {1'b0, w} - {1'b0, r};
		if (w < r) begin
			diff = diff + DEPTH_X;
		end
		ext = CNT_X'(diff);
		return ext[COUNT_W-1:0];
	endfunction

	// Decode ring status and the operation of the held transaction
	always_comb begin
		op       = mode_t'(mode_q);
		rx_w_nx  = next_pos(rx_w_q);
		rx_r_nx  = next_pos(rx_r_q);
		tx_w_nx  = next_pos(tx_w_q);
		tx_r_nx  = next_pos(tx_r_q);
		rx_full  = (rx_w_nx == rx_r_q);
		rx_empty = (rx_w_q == rx_r_q);
		tx_full  = (tx_w_nx == tx_r_q);
		tx_empty = (tx_w_q == tx_r_q);
		rx_push  = cmd.exec && (op == MODE_RX_BYTE)  && !rx_full;
		tx_pop   = cmd.exec && (op == MODE_TX_READY) && !tx_empty;
		rx_pop   = cmd.exec && (op == MODE_SW_READ)  && !rx_empty;
		tx_push  = cmd.exec && (op == MODE_SW_WRITE) && !tx_full;
	end

	// Capture the incoming transaction
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			mode_q <= mode;
			din_q  <= data_in;
		end
	end

	// Write and read the ring memories; a transaction without a pop returns zero
	always_ff @(posedge clk) begin
		if (rx_push) begin
			rx_mem[rx_w_q] <= din_q;
		end
		if (tx_push) begin
			tx_mem[tx_w_q] <= din_q;
		end
		if (tx_pop) begin
			rd_q <= tx_mem[tx_r_q];
		end else if (rx_pop) begin
			rd_q <= rx_mem[rx_r_q];
		end else if (cmd.exec) begin
			rd_q <= '0;
		end
	end

	// Advance pointers, track the transmit enable and record success
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_w_q  <= '0;
			rx_r_q  <= '0;
			tx_w_q  <= '0;
			tx_r_q  <= '0;
			tx_en_q <= 1'b0;
			ok_q    <= 1'b0;
		end else if (cmd.exec) begin
			ok_q <= rx_push || tx_pop || rx_pop || tx_push;
			if (rx_push) begin
				rx_w_q <= rx_w_nx;
			end
			if (rx_pop) begin
				rx_r_q <= rx_r_nx;
			end
			if (tx_push) begin
				tx_w_q  <= tx_w_nx;
				tx_en_q <= 1'b1;
			end
			if (tx_pop) begin
				tx_r_q <= tx_r_nx;
			end
			// drop the enable once the transmit ring runs dry
			if ((op == MODE_TX_READY) && (tx_empty || (tx_r_nx == tx_w_q))) begin
				tx_en_q <= 1'b0;
			end
		end
	end

	// Present the result
	always_comb begin
		data_out      = ok_q ? rd_q : '0;
		ok            = ok_q;
		tx_irq_enable = tx_en_q;
		rx_count      = fill(rx_w_q, rx_r_q);
		tx_count      = fill(tx_w_q, tx_r_q);
	end

endmodule

// ===== rtl/uart_byte_fifo_buffering.sv =====
// Top level of the UART byte FIFO buffering block.
// Instantiates ubf_ctrl and ubf_dpath; depends on ubf_pkg.
//
// Receive and transmit byte rings between a serial line and software; each
// holds up to DEPTH-1 bytes. A transaction is taken when start is high and
// busy is low; busy is high for the one cycle in which the ring memory is
// written or read, and the result appears on the next cycle with done high
// for exactly one cycle. The receiver cannot stall: capture the result in
// the done cycle. A new start may be given in the done cycle itself and is
// latched while the last result shows; each transaction passes the registered
// memory access and then the result cycle. mode 0 stores a line byte, mode 1
// pops for the transmitter and clears tx_irq_enable when the ring empties,
// mode 2 is a software read, mode 3 a software write that sets tx_irq_enable.
module uart_byte_fifo_buffering #(
	parameter int DEPTH = ubf_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [ubf_pkg::MODE_W-1:0]  mode,
	input  logic [ubf_pkg::DATA_W-1:0]  data_in,
	output logic                        done,
	output logic [ubf_pkg::DATA_W-1:0]  data_out,
	output logic                        ok,
	output logic                        tx_irq_enable,
	output logic [ubf_pkg::COUNT_W-1:0] rx_count,
	output logic [ubf_pkg::COUNT_W-1:0] tx_count
);
	import ubf_pkg::*;

	cmd_t cmd;

	// Sequence each transaction
	ubf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Hold the rings and build the result
	ubf_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.mode          (mode),
		.data_in       (data_in),
		.data_out      (data_out),
		.ok            (ok),
		.tx_irq_enable (tx_irq_enable),
		.rx_count      (rx_count),
		.tx_count      (tx_count)
	);

endmodule
